// ===== hdl/ittl_pkg.sv =====
// ----------------------------------------------------------------------------
// ittl_pkg
// Shared constants and types of the TTL / hop-limit rewriter.
// ----------------------------------------------------------------------------
package ittl_pkg;

    localparam int MAX_HEADER_BYTES = 60;
    localparam int MIN_HEADER_BYTES = 20;
    localparam int HDR_LEN_W        = 6;
    localparam int POS_W            = 16;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    localparam int HOP_LIMIT_POS    = 7;
    localparam int TTL_POS          = 8;
    localparam int CSUM_HI_POS      = 10;
    localparam int CSUM_LO_POS      = 11;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86dd;

    localparam logic [7:0]  NEW_TTL_RESET    = 8'd64;
    localparam logic [15:0] SIZE_LIMIT_RESET = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_NEW_TTL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 1'd1;

    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_V6      = 2'd1;
    localparam logic [1:0] MODE_V4_HDR  = 2'd2;
    localparam logic [1:0] MODE_V4_BODY = 2'd3;

    typedef struct packed {
        logic       fill;
        logic       drain;
        logic       csum_wr;
        logic [7:0] fill_byte;
        logic [15:0] csum;
    } cell_ctl_t;

    typedef struct packed {
        logic [7:0] head_byte;
        logic       next_valid;
    } chain_head_t;

endpackage

// ===== hdl/ittl_cell.sv =====
// ----------------------------------------------------------------------------
// ittl_cell
// One header byte cell: fills at the frontier, shifts toward the head on drain, takes a checksum byte on csum_we.
// ----------------------------------------------------------------------------
module ittl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  ittl_pkg::cell_ctl_t ctl,
    input  logic               csum_we,
    input  logic [7:0]         csum_byte,
    input  logic               lower_valid,
    input  logic               upper_valid,
    input  logic [7:0]         upper_byte,
    output logic               valid,
    output logic [7:0]         data
);
    import ittl_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;
    logic       take_fill;

    assign take_fill = ctl.fill && lower_valid && !valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctl.drain)
        begin
            valid_next = upper_valid;
            data_next  = upper_byte;
        end
        else if (take_fill)
        begin
            valid_next = 1'b1;
            data_next  = ctl.fill_byte;
        end
        else if (csum_we)
        begin
            data_next = csum_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== hdl/ittl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ittl_ctrl
// Packet classification, byte position, checksum, release and output register.
// ----------------------------------------------------------------------------
module ittl_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pkt_byte,
    input  logic                            last_byte,
    input  logic [15:0]                     ether_type,
    input  logic [15:0]                     packet_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            out_last,
    input  logic                            cfg_wr_en,
    input  logic [ittl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ittl_pkg::CFG_DATA_W-1:0] cfg_data,
    output ittl_pkg::cell_ctl_t             cell_ctl,
    input  ittl_pkg::chain_head_t           head
);
    import ittl_pkg::*;

    localparam logic [HDR_LEN_W-1:0] HDR_MIN = HDR_LEN_W'(MIN_HEADER_BYTES);
    localparam logic [HDR_LEN_W-1:0] HDR_MAX = HDR_LEN_W'(MAX_HEADER_BYTES);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [15:0]          csum_reg, csum_next;
    logic [HDR_LEN_W-1:0] hlen_reg, hlen_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 drain_reg, drain_next;
    logic                 drain_last_reg, drain_last_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic [7:0]           new_ttl_reg;
    logic [15:0]          size_limit_reg;

    logic                 in_fire;
    logic                 out_free;
    logic                 drain_step;
    logic                 first;
    logic [1:0]           mode_eff;
    logic [HDR_LEN_W-1:0] ihl_bytes;
    logic [HDR_LEN_W-1:0] hlen_eff;
    logic [7:0]           v;
    logic [15:0]          acc_base;
    logic [15:0]          w;
    logic [16:0]          sum17;
    logic [15:0]          acc_new;
    logic                 hdr_done;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_ready   = !drain_reg && out_free;
    assign in_fire    = in_valid && in_ready;
    assign drain_step = drain_reg && out_free;
    assign first      = (pos_reg == '0);
    assign ihl_bytes  = {pkt_byte[3:0], 2'b00};

    always_comb
    begin
        if (packet_length > size_limit_reg)
            mode_eff = MODE_PASS;
        else if (ether_type == ETH_IPV4)
            mode_eff = MODE_V4_HDR;
        else if (ether_type == ETH_IPV6)
            mode_eff = MODE_V6;
        else
            mode_eff = MODE_PASS;
        if (!first)
            mode_eff = mode_reg;

        if (!first)
            hlen_eff = hlen_reg;
        else if (ihl_bytes < HDR_MIN)
            hlen_eff = HDR_MIN;
        else if (ihl_bytes > HDR_MAX)
            hlen_eff = HDR_MAX;
        else
            hlen_eff = ihl_bytes;

        v = pkt_byte;
        if (mode_eff == MODE_V4_HDR && pos_reg == POS_W'(TTL_POS))
            v = new_ttl_reg;
        if (mode_eff == MODE_V6 && pos_reg == POS_W'(HOP_LIMIT_POS))
            v = new_ttl_reg;

        acc_base = first ? 16'd0 : csum_reg;
        w        = pos_reg[0] ? {8'd0, v} : {v, 8'd0};
        sum17    = {1'b0, acc_base} + {1'b0, w};
        if (pos_reg == POS_W'(CSUM_HI_POS) || pos_reg == POS_W'(CSUM_LO_POS))
            acc_new = acc_base;
        else
            acc_new = sum17[15:0] + {15'd0, sum17[16]};

        hdr_done = ({1'b0, pos_reg} + 17'd1) >= {{(17-HDR_LEN_W){1'b0}}, hlen_eff};
    end

    always_comb
    begin
        pos_next        = pos_reg;
        csum_next       = csum_reg;
        hlen_next       = hlen_reg;
        mode_next       = mode_reg;
        drain_next      = drain_reg;
        drain_last_next = drain_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        cell_ctl.fill      = 1'b0;
        cell_ctl.drain     = drain_step;
        cell_ctl.csum_wr   = 1'b0;
        cell_ctl.fill_byte = v;
        cell_ctl.csum      = ~acc_new;

        if (drain_step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = head.head_byte;
            out_last_next  = drain_last_reg && !head.next_valid;
            if (!head.next_valid)
                drain_next = 1'b0;
        end

        if (in_fire)
        begin
            mode_next = mode_eff;
            hlen_next = hlen_eff;
            csum_next = acc_new;
            if (mode_eff == MODE_V4_HDR)
            begin
                cell_ctl.fill = 1'b1;
                if (hdr_done)
                begin
                    cell_ctl.csum_wr = 1'b1;
                    drain_next       = 1'b1;
                    drain_last_next  = last_byte;
                    mode_next        = MODE_V4_BODY;
                end
                else if (last_byte)
                begin
                    drain_next      = 1'b1;
                    drain_last_next = 1'b1;
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                out_byte_next  = v;
                out_last_next  = last_byte;
            end

            if (last_byte)
            begin
                pos_next  = '0;
                csum_next = '0;
                hlen_next = '0;
                mode_next = MODE_PASS;
            end
            else if (pos_reg != '1)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            csum_reg       <= '0;
            hlen_reg       <= '0;
            mode_reg       <= MODE_PASS;
            drain_reg      <= 1'b0;
            drain_last_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            new_ttl_reg    <= NEW_TTL_RESET;
            size_limit_reg <= SIZE_LIMIT_RESET;
        end
        else
        begin
            pos_reg        <= pos_next;
            csum_reg       <= csum_next;
            hlen_reg       <= hlen_next;
            mode_reg       <= mode_next;
            drain_reg      <= drain_next;
            drain_last_reg <= drain_last_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NEW_TTL:    new_ttl_reg    <= cfg_data[7:0];
                    CFG_SIZE_LIMIT: size_limit_reg <= cfg_data[15:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== hdl/ip_ttl_hop_limit_rewriter_top.sv =====
// ----------------------------------------------------------------------------
// ip_ttl_hop_limit_rewriter_top
// Rewrites IPv4 TTL / IPv6 hop limit and regenerates the IPv4 header checksum.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_ready   pkt_byte, last_byte, ether_type,
//                                              packet_length
//   out       source     out_valid / out_ready out_byte, out_last
//   cfg       sink       cfg_wr_en             cfg_index, cfg_data
//
// Pass-through and IPv6 bytes: one item per cycle while the output is free,
// each result registered for the next cycle. IPv4 header bytes fill the
// cell chain one per cycle with no result; the header (IHL*4 held to 20..60,
// or the bytes held so far on an early end) is then released from the head
// of the chain, one byte per cycle while the output is free; the input is held.
// A stalled output holds the input. Reset clears all control state at once.
// ----------------------------------------------------------------------------
module ip_ttl_hop_limit_rewriter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      pkt_byte,
    input  logic                            last_byte,
    input  logic [15:0]                     ether_type,
    input  logic [15:0]                     packet_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      out_byte,
    output logic                            out_last,
    input  logic                            cfg_wr_en,
    input  logic [ittl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ittl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ittl_pkg::*;

    cell_ctl_t   cell_ctl;
    chain_head_t head;
    logic        cell_valid [MAX_HEADER_BYTES];
    logic [7:0]  cell_data  [MAX_HEADER_BYTES];

    ittl_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pkt_byte      (pkt_byte),
        .last_byte     (last_byte),
        .ether_type    (ether_type),
        .packet_length (packet_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_ctl      (cell_ctl),
        .head          (head)
    );

    assign head = {cell_data[0], cell_valid[1]};

    for (genvar k = 0; k < MAX_HEADER_BYTES; k++)
    begin : g_cell
        logic       lower_valid;
        logic       upper_valid;
        logic [7:0] upper_byte;
        logic       csum_we;
        logic [7:0] csum_byte;

        if (k == 0)
        begin : g_first
            assign lower_valid = 1'b1;
        end
        else
        begin : g_mid
            assign lower_valid = cell_valid[k-1];
        end

        if (k == MAX_HEADER_BYTES - 1)
        begin : g_top
            assign upper_valid = 1'b0;
            assign upper_byte  = 8'd0;
        end
        else
        begin : g_below
            assign upper_valid = cell_valid[k+1];
            assign upper_byte  = cell_data[k+1];
        end

        if (k == CSUM_HI_POS)
        begin : g_csum_hi
            assign csum_we   = cell_ctl.csum_wr;
            assign csum_byte = cell_ctl.csum[15:8];
        end
        else if (k == CSUM_LO_POS)
        begin : g_csum_lo
            assign csum_we   = cell_ctl.csum_wr;
            assign csum_byte = cell_ctl.csum[7:0];
        end
        else
        begin : g_plain
            assign csum_we   = 1'b0;
            assign csum_byte = 8'd0;
        end

        ittl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .csum_we     (csum_we),
            .csum_byte   (csum_byte),
            .lower_valid (lower_valid),
            .upper_valid (upper_valid),
            .upper_byte  (upper_byte),
            .valid       (cell_valid[k]),
            .data        (cell_data[k])
        );
    end

endmodule

// ===== hdl/ittl_checker.sv =====
// ----------------------------------------------------------------------------
// ittl_checker
// Port-level checks of the rewriter, bound to the top level.
// ----------------------------------------------------------------------------
module ittl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output item changed while stalled");

    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

    a_reset_release: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind ip_ttl_hop_limit_rewriter_top ittl_checker u_ittl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of IPv4, IPv6 and other packets into the TTL / hop-limit
// rewriter under random input gaps and output stalls, predicts every output
// item with an internal model of the header rewrite and checksum, and compares
// each output item against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;

    import ittl_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [7:0]            pkt_byte      = 8'h00;
    logic                  last_byte     = 1'b0;
    logic [15:0]           ether_type    = 16'h0000;
    logic [15:0]           packet_length = 16'h0000;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic [7:0]            out_byte;
    logic                  out_last;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    out_item_t   expected_bytes[$];
    int          mismatches  = 0;
    bit          quiet       = 1'b0;
    int          holds_asked = 0;
    int          holds_done  = 0;
    int          hold_left   = 0;

    logic [7:0]  ttl_value    = NEW_TTL_RESET;
    logic [15:0] length_limit = SIZE_LIMIT_RESET;
    logic [7:0]  hdr_copy[MAX_HEADER_BYTES];
    int unsigned cur_pos  = 0;
    int unsigned sum_acc  = 0;
    int unsigned hdr_len  = 0;
    logic [1:0]  cur_mode = MODE_PASS;

    ip_ttl_hop_limit_rewriter_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pkt_byte      (pkt_byte),
        .last_byte     (last_byte),
        .ether_type    (ether_type),
        .packet_length (packet_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .out_last      (out_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned fold16(input int unsigned s);
        while (s > 32'hFFFF)
            s = (s & 32'hFFFF) + (s >> 16);
        return s;
    endfunction

    function automatic void rewrite_byte(input logic [7:0] b, input logic lst,
                                         input logic [15:0] et, input logic [15:0] plen);
        logic [7:0]  v;
        logic [15:0] csum;
        int unsigned w;
        v = b;
        if (cur_pos == 0)
        begin
            if (plen > length_limit)
                cur_mode = MODE_PASS;
            else if (et == ETH_IPV4)
                cur_mode = MODE_V4_HDR;
            else if (et == ETH_IPV6)
                cur_mode = MODE_V6;
            else
                cur_mode = MODE_PASS;
            sum_acc = 0;
            hdr_len = 0;
        end
        if (cur_mode == MODE_V4_HDR)
        begin
            if (cur_pos == 0)
            begin
                hdr_len = b[3:0] * 4;
                if (hdr_len < MIN_HEADER_BYTES)
                    hdr_len = MIN_HEADER_BYTES;
                if (hdr_len > MAX_HEADER_BYTES)
                    hdr_len = MAX_HEADER_BYTES;
            end
            if (cur_pos == TTL_POS)
                v = ttl_value;
            hdr_copy[cur_pos] = v;
            if (cur_pos != CSUM_HI_POS && cur_pos != CSUM_LO_POS)
            begin
                w = cur_pos[0] ? {24'h0, v} : {16'h0, v, 8'h00};
                sum_acc = fold16(sum_acc + w) & 32'hFFFFF;
            end
            if (cur_pos + 1 >= hdr_len)
            begin
                csum = 16'(~fold16(sum_acc));
                hdr_copy[CSUM_HI_POS] = csum[15:8];
                hdr_copy[CSUM_LO_POS] = csum[7:0];
                for (int i = 0; i < hdr_len; i++)
                    expected_bytes.push_back(out_item_t'{data: hdr_copy[i],
                                                         last: lst && (i + 1 == hdr_len)});
                cur_mode = MODE_V4_BODY;
            end
            else if (lst)
            begin
                for (int i = 0; i <= cur_pos; i++)
                    expected_bytes.push_back(out_item_t'{data: hdr_copy[i],
                                                         last: (i == cur_pos)});
            end
        end
        else
        begin
            if (cur_mode == MODE_V6 && cur_pos == HOP_LIMIT_POS)
                v = ttl_value;
            expected_bytes.push_back(out_item_t'{data: v, last: lst});
        end
        if (lst)
        begin
            cur_pos  = 0;
            sum_acc  = 0;
            hdr_len  = 0;
            cur_mode = MODE_PASS;
        end
        else if (cur_pos < 32'hFFFF)
            cur_pos++;
    endfunction

    always @(negedge clk)
    begin
        if (hold_left == 0 && holds_done != holds_asked)
        begin
            hold_left = 400;
            holds_done++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= quiet || ($urandom_range(99) >= 8);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: byte %02h last %0b", out_byte, out_last);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data || out_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, out_byte, out_last);
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst,
                             input logic [15:0] et, input logic [15:0] plen);
        @(negedge clk);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        pkt_byte      <= b;
        last_byte     <= lst;
        ether_type    <= et;
        packet_length <= plen;
        do
            @(posedge clk);
        while (!in_ready);
        rewrite_byte(b, lst, et, plen);
    endtask

    task automatic send_packet(input logic [15:0] et, input logic [15:0] plen,
                               input int nbytes, input logic [7:0] first);
        for (int i = 0; i < nbytes; i++)
            send_byte((i == 0) ? first : 8'($urandom), i == nbytes - 1, et, plen);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        settle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_NEW_TTL)
            ttl_value = data[7:0];
        else
            length_limit = data;
    endtask

    task automatic test_pass_through();
        send_packet(16'h0000, 16'd3, 3, 8'hFF);
        send_packet(16'hFFFF, 16'd2, 2, 8'h00);
        send_packet(16'h1234, 16'd1, 1, 8'hA5);
        send_packet(ETH_IPV4, 16'd40000, 9, 8'h45);
        send_packet(ETH_IPV6, 16'd32769, 8, 8'h60);
    endtask

    task automatic test_ipv6_hop_limit();
        send_packet(ETH_IPV6, 16'd10, 10, 8'h60);
        send_packet(ETH_IPV6, 16'd7, 7, 8'h60);
        send_packet(ETH_IPV6, 16'd8, 8, 8'h6F);
    endtask

    task automatic test_ipv4_header();
        send_packet(ETH_IPV4, 16'd24, 24, 8'h45);
        send_packet(ETH_IPV4, 16'd22, 22, 8'h40);
        send_packet(ETH_IPV4, 16'd20, 20, 8'hF4);
        send_packet(ETH_IPV4, SIZE_LIMIT_RESET, 21, 8'h45);
    endtask

    task automatic test_ipv4_early_end();
        send_packet(ETH_IPV4, 16'd1, 1, 8'h45);
        send_packet(ETH_IPV4, 16'd8, 8, 8'h45);
        send_packet(ETH_IPV4, 16'd9, 9, 8'h45);
        send_packet(ETH_IPV4, 16'd12, 12, 8'h45);
        send_packet(ETH_IPV4, 16'd30, 30, 8'h4F);
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_NEW_TTL, 16'h0001);
        send_packet(ETH_IPV4, 16'd20, 20, 8'h45);
        send_packet(ETH_IPV6, 16'd8, 8, 8'h60);
        write_reg(CFG_NEW_TTL, 16'hFFFF);
        send_packet(ETH_IPV4, 16'd20, 20, 8'h45);
        send_packet(ETH_IPV6, 16'd8, 8, 8'h60);
        write_reg(CFG_SIZE_LIMIT, 16'h0000);
        send_packet(ETH_IPV4, 16'd0, 20, 8'h45);
        send_packet(ETH_IPV4, 16'd1, 3, 8'h45);
        send_packet(ETH_IPV6, 16'd1, 8, 8'h60);
        write_reg(CFG_SIZE_LIMIT, 16'hFFFF);
        send_packet(ETH_IPV4, 16'hFFFF, 20, 8'h45);
        send_packet(ETH_IPV6, 16'hFFFF, 8, 8'h60);
    endtask

    task automatic test_backpressure();
        logic [3:0] ihl;
        holds_asked++;
        for (int p = 0; p < 2; p++)
        begin
            ihl = 4'($urandom_range(5, 15));
            send_packet(ETH_IPV4, 16'd100, ihl * 4 + 4, {4'h4, ihl});
        end
        send_packet(ETH_IPV6, 16'd10, 10, 8'h60);
        settle();
    endtask

    task automatic test_long_packet();
        quiet = 1'b1;
        send_packet(ETH_IPV4, 16'd64, 64, 8'h4F);
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_random();
        int          sent;
        int          kind;
        int          hdr;
        int          nbytes;
        logic [3:0]  ihl;
        logic [15:0] plen;
        for (int seg = 0; seg < 3; seg++)
        begin
            write_reg(CFG_NEW_TTL, {8'($urandom), 8'($urandom_range(1, 255))});
            write_reg(CFG_SIZE_LIMIT, (seg == 1) ? 16'($urandom_range(0, 80)) : 16'hFFFF);
            sent = 0;
            while (sent < 10)
            begin
                kind = $urandom_range(99);
                if (kind < 70)
                begin
                    if ($urandom_range(99) < 50)
                        ihl = 4'd5;
                    else if ($urandom_range(99) < 15)
                        ihl = 4'($urandom_range(0, 4));
                    else
                        ihl = 4'($urandom_range(5, 15));
                    hdr = (ihl < 5) ? MIN_HEADER_BYTES : ihl * 4;
                    if ($urandom_range(99) < 15)
                        nbytes = $urandom_range(1, hdr - 1);
                    else
                        nbytes = hdr + $urandom_range(0, 10);
                    plen = ($urandom_range(99) < 85) ? 16'(nbytes) : 16'($urandom);
                    send_packet(ETH_IPV4, plen, nbytes, {4'($urandom), ihl});
                end
                else if (kind < 85)
                begin
                    nbytes = $urandom_range(1, 16);
                    plen = ($urandom_range(99) < 85) ? 16'(nbytes) : 16'($urandom);
                    send_packet(ETH_IPV6, plen, nbytes, 8'($urandom));
                end
                else
                begin
                    nbytes = $urandom_range(1, 8);
                    send_packet(16'($urandom), 16'($urandom), nbytes, 8'($urandom));
                end
                sent += nbytes;
            end
        end
    endtask

    initial
    begin
        int guard;
        foreach (hdr_copy[i])
            hdr_copy[i] = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_ipv6_hop_limit();
        test_ipv4_header();
        test_ipv4_early_end();
        test_config_extremes();
        test_backpressure();
        test_long_packet();
        test_random();

        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (expected_bytes.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
        if (expected_bytes.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ittl_pkg.sv
hdl/ittl_cell.sv
hdl/ittl_ctrl.sv
hdl/ip_ttl_hop_limit_rewriter_top.sv
hdl/ittl_checker.sv
tb/testbench.sv
